// ----- design/dsort_pkg.sv -----
// Shared widths, defaults and control types for the descending sort engine.
package dsort_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int SCORE_W      = 16;
  localparam int VAL_W        = 15;

  typedef logic [VAL_W-1:0] val_t;

  // Control word broadcast along the cell chain
  typedef struct packed {
    logic insert;  // place a new score in sorted position
    logic drain;   // shift every value one cell toward the head
  } cell_ctrl_t;

endpackage

// ----- design/dsort_cell.sv -----
// One cell of the insertion chain: holds one score, swaps with its neighbors.
module dsort_cell import dsort_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  val_t             new_val,
  input  logic [CNT_W-1:0] count,
  input  val_t             prev_val,
  input  logic             prev_gt,
  input  val_t             next_val,
  output val_t             val,
  output logic             gt
);

  val_t val_r;
  val_t val_nxt;

  // Flag a cell the new score must displace: empty, or holding a smaller value
  assign gt  = (CNT_W'(IDX) >= count) || (new_val > val_r);
  assign val = val_r;

  // Take the upper neighbor's value, the new score, or hold
  always_comb begin
    val_nxt = val_r;
    if (ctrl.insert) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt) begin
        val_nxt = new_val;
      end
    end else if (ctrl.drain) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- design/descending_sort_engine_core.sv -----
// Top level: insertion sort chain that collects scores and emits them largest first.
// The first result appears in the cycle after the end marker or the insert that fills the chain.
// Throughput: one request per cycle while loading; the drain gives one result per cycle,
//   and busy stays high from the first result through the last.
// Each insert is one compare per cell; the drain shifts the chain toward cell 0.
// Reset (rst_n low, synchronous) empties the set and stops any drain in progress.
// Results are strobed by out_valid for one cycle each; the receiver cannot stall.
module descending_sort_engine_core import dsort_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [SCORE_W-1:0] in_score,
  output logic               out_valid,
  output logic [VAL_W-1:0]   out_sorted_value,
  output logic               out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             accept;
  logic             is_end;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             drain_r;
  logic             drain_nxt;
  cell_ctrl_t       ctrl;
  val_t             new_val;
  val_t             vals [CAPACITY];
  logic             gts  [CAPACITY];

  assign accept  = start && !drain_r;
  assign is_end  = in_score[SCORE_W-1];
  assign new_val = in_score[VAL_W-1:0];

  assign ctrl.insert = accept && !is_end;
  assign ctrl.drain  = drain_r;

  // Advance the fill count and decide when the set ends
  always_comb begin
    count_nxt = count_r;
    drain_nxt = drain_r;
    if (drain_r) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        drain_nxt = 1'b0;
      end
    end else if (accept) begin
      if (is_end) begin
        drain_nxt = (count_r != '0);
      end else begin
        count_nxt = count_r + CNT_W'(1);
        drain_nxt = (count_r == CNT_W'(CAPACITY - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drain_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drain_r <= drain_nxt;
    end
  end

  // Build the chain of cells, each linked to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    val_t pv;
    logic pg;
    val_t nv;
    if (i == 0) begin : g_head
      assign pv = '0;
      assign pg = 1'b0;
    end else begin : g_body
      assign pv = vals[i-1];
      assign pg = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign nv = '0;
    end else begin : g_inner
      assign nv = vals[i+1];
    end
    dsort_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_val  (new_val),
      .count    (count_r),
      .prev_val (pv),
      .prev_gt  (pg),
      .next_val (nv),
      .val      (vals[i]),
      .gt       (gts[i])
    );
  end

  // Present the head cell while draining
  assign busy             = drain_r;
  assign out_valid        = drain_r;
  assign out_sorted_value = vals[0];
  assign out_last         = drain_r && (count_r == CNT_W'(1));

`ifndef ASSERT_OFF
  a_valid_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_r != '0)
    else $error("result strobed with an empty chain");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after the last flag");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("run stopped before the last flag");

  a_descending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_sorted_value <= $past(out_sorted_value))
    else $error("run not in descending order");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");
`endif

endmodule
